[sv/qmnf_pkg.sv]
`default_nettype none

package qmnf_pkg;

  localparam int NODE_W  = 12;
  localparam int QUERY_W = 10;
  localparam int NBR_W   = 12;
  localparam int NFACES  = 4;

  typedef logic [NODE_W-1:0] node_t;

  // corners 0..3 sit from the lowest bit up
  typedef struct packed {
    node_t d;
    node_t c;
    node_t b;
    node_t a;
  } cell_t;

  typedef struct packed {
    node_t s1;
    node_t s0;
  } seg_t;

  typedef struct packed {
    node_t r;
    node_t s;
  } face_t;

  typedef face_t [NFACES-1:0] face_set_t;

  typedef enum logic [1:0] {
    OP_LOAD_CELL = 2'd0,
    OP_LOAD_SEG  = 2'd1,
    OP_QUERY     = 2'd2,
    OP_CLEAR     = 2'd3
  } op_t;

  // write strobes toward the stores
  typedef struct packed {
    logic cell_we;
    logic seg_we;
  } store_we_t;

  // faces over corners 0-1, 1-3, 3-2, 2-0
  function automatic face_set_t cell_faces(cell_t c);
    face_set_t fs;
    fs[0].r = c.a;
    fs[0].s = c.b;
    fs[1].r = c.b;
    fs[1].s = c.d;
    fs[2].r = c.d;
    fs[2].s = c.c;
    fs[3].r = c.c;
    fs[3].s = c.a;
    return fs;
  endfunction

endpackage

`default_nettype wire

[sv/qmnf_face_cmp.sv]
`default_nettype none

// compares the four query faces against four candidate faces
module qmnf_face_cmp
  import qmnf_pkg::*;
(
  input  face_set_t          qry,
  input  face_set_t          cand,
  output logic [NFACES-1:0]  hit
);

  always_comb begin
    hit = '0;
    for (int f = 0; f < NFACES; f++) begin
      for (int g = 0; g < NFACES; g++) begin
        if ((qry[f].r == cand[g].r || qry[f].r == cand[g].s) &&
            (qry[f].s == cand[g].r || qry[f].s == cand[g].s)) begin
          hit[f] = 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

[sv/qmnf_store.sv]
`default_nettype none

// cell and segment memories, one write and one registered read port each
module qmnf_store
  import qmnf_pkg::*;
#(
  parameter int CELL_DEPTH = 1024,
  parameter int SEG_DEPTH  = 256,
  parameter int CAW        = 10,
  parameter int SAW        = 8
)(
  input  logic            clk,
  input  store_we_t       we,
  input  logic [CAW-1:0]  cell_waddr,
  input  cell_t           cell_wdata,
  input  logic [CAW-1:0]  cell_raddr,
  output cell_t           cell_rdata,
  input  logic [SAW-1:0]  seg_waddr,
  input  seg_t            seg_wdata,
  input  logic [SAW-1:0]  seg_raddr,
  output seg_t            seg_rdata
);

  cell_t cell_mem [CELL_DEPTH];
  seg_t  seg_mem  [SEG_DEPTH];

  always_ff @(posedge clk) begin
    if (we.cell_we) begin
      cell_mem[cell_waddr] <= cell_wdata;
    end
    cell_rdata <= cell_mem[cell_raddr];
  end

  always_ff @(posedge clk) begin
    if (we.seg_we) begin
      seg_mem[seg_waddr] <= seg_wdata;
    end
    seg_rdata <= seg_mem[seg_raddr];
  end

endmodule

`default_nettype wire

[sv/quad_mesh_face_neighbour_finder.sv]
`default_nettype none

// channel  dir  handshake          payload
// s_*      in   s_tvalid/s_tready  tuser: op; tdata: corners a..d, query_cell
// m_*      out  m_tvalid/m_tready  tuser: index_ok; tdata: cell_index, nbr_face0..3
//
// loads and clear leave the block ready
// a query holds s_tready low until its result enters the output register
// (a cell index out of range skips the scans); each store has one read port
// that delivers one entry per cycle, and the shared compare unit checks
// all four faces of the query cell against that entry
// rst zeroes both counts and the control; the stores are not cleared
// a result waits in the output register while m_tready is low; a query
// that finishes meanwhile holds until that register is free
module quad_mesh_face_neighbour_finder
  import qmnf_pkg::*;
#(
  parameter int MAX_CELLS    = 1024,
  parameter int MAX_SEGMENTS = 256
)(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // corner_a, corner_b, corner_c, corner_d, query_cell
  input  logic [1:0]  s_tuser,   // op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // cell_index, nbr_face0, nbr_face1, nbr_face2, nbr_face3
  output logic        m_tuser    // index_ok
);

  localparam int CAW  = $clog2(MAX_CELLS);
  localparam int CNTW = $clog2(MAX_CELLS + 1);
  localparam int SAW  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int SCW  = $clog2(MAX_SEGMENTS + 1);
  localparam int CMPW = (CNTW > QUERY_W) ? CNTW : QUERY_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_QLOAD,
    ST_CSCAN,
    ST_SSCAN,
    ST_FINISH
  } state_t;

  state_t                         state;
  logic [CNTW-1:0]                cell_count;
  logic [SCW-1:0]                 seg_count;
  logic [QUERY_W-1:0]             q_reg;
  logic                           ok_reg;
  cell_t                          qry;
  logic [CAW-1:0]                 cidx;
  logic [SAW-1:0]                 sidx;
  logic [NFACES-1:0][NBR_W-1:0]   nbr;
  logic [NFACES-1:0]              cell_found;
  logic [NFACES-1:0]              seg_found;
  logic                           out_valid;
  logic [63:0]                    out_data;
  logic                           out_ok;

  logic                           accept;
  op_t                            op;
  logic [QUERY_W-1:0]             in_query;
  store_we_t                      we;
  logic [CAW-1:0]                 cell_raddr;
  logic [SAW-1:0]                 seg_raddr;
  cell_t                          cell_wdata;
  seg_t                           seg_wdata;
  cell_t                          cell_rdata;
  seg_t                           seg_rdata;
  face_set_t                      cand;
  logic [NFACES-1:0]              hit;
  logic                           cell_last;
  logic                           seg_last;
  logic                           self_hit;
  logic [NBR_W-1:0]               seg_code;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign op       = op_t'(s_tuser);
  assign in_query = s_tdata[57:48];

  assign cell_wdata.a = s_tdata[11:0];
  assign cell_wdata.b = s_tdata[23:12];
  assign cell_wdata.c = s_tdata[35:24];
  assign cell_wdata.d = s_tdata[47:36];
  assign seg_wdata.s0 = s_tdata[11:0];
  assign seg_wdata.s1 = s_tdata[23:12];

  // loads past capacity are dropped
  assign we.cell_we = accept && (op == OP_LOAD_CELL) && (cell_count < CNTW'(MAX_CELLS));
  assign we.seg_we  = accept && (op == OP_LOAD_SEG) && (seg_count < SCW'(MAX_SEGMENTS));

  // read address runs one entry ahead of the compare
  always_comb begin
    unique case (state)
      ST_IDLE:  cell_raddr = CAW'(in_query);
      ST_CSCAN: cell_raddr = cidx + 1'b1;
      default:  cell_raddr = '0;
    endcase
  end

  assign seg_raddr = (state == ST_SSCAN) ? sidx + 1'b1 : '0;

  qmnf_store #(
    .CELL_DEPTH (MAX_CELLS),
    .SEG_DEPTH  (MAX_SEGMENTS),
    .CAW        (CAW),
    .SAW        (SAW)
  ) u_store (
    .clk        (clk),
    .we         (we),
    .cell_waddr (cell_count[CAW-1:0]),
    .cell_wdata (cell_wdata),
    .cell_raddr (cell_raddr),
    .cell_rdata (cell_rdata),
    .seg_waddr  (seg_count[SAW-1:0]),
    .seg_wdata  (seg_wdata),
    .seg_raddr  (seg_raddr),
    .seg_rdata  (seg_rdata)
  );

  // a segment is offered as the same face four times
  always_comb begin
    if (state == ST_SSCAN) begin
      for (int g = 0; g < NFACES; g++) begin
        cand[g].r = seg_rdata.s0;
        cand[g].s = seg_rdata.s1;
      end
    end else begin
      cand = cell_faces(cell_rdata);
    end
  end

  qmnf_face_cmp u_cmp (
    .qry  (cell_faces(qry)),
    .cand (cand),
    .hit  (hit)
  );

  assign cell_last = (CNTW'(cidx) == cell_count - 1'b1);
  assign seg_last  = (SCW'(sidx) == seg_count - 1'b1);
  assign self_hit  = (CMPW'(cidx) == CMPW'(q_reg));
  assign seg_code  = NBR_W'(cell_count) + NBR_W'(sidx);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cell_count <= '0;
      seg_count  <= '0;
      out_valid  <= 1'b0;
    end else begin
      // in ST_FINISH the output register is either refilled or kept
      if (m_tready && state != ST_FINISH) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            case (op)
              OP_LOAD_CELL: begin
                if (we.cell_we) begin
                  cell_count <= cell_count + 1'b1;
                end
              end
              OP_LOAD_SEG: begin
                if (we.seg_we) begin
                  seg_count <= seg_count + 1'b1;
                end
              end
              OP_CLEAR: begin
                cell_count <= '0;
                seg_count  <= '0;
              end
              default: begin
                // query: neighbours start as none found
                q_reg      <= in_query;
                ok_reg     <= (CMPW'(in_query) < CMPW'(cell_count));
                nbr        <= '1;
                cell_found <= '0;
                seg_found  <= '0;
                state      <= (CMPW'(in_query) < CMPW'(cell_count)) ? ST_QLOAD : ST_FINISH;
              end
            endcase
          end
        end
        ST_QLOAD: begin
          qry   <= cell_rdata;
          cidx  <= '0;
          state <= ST_CSCAN;
        end
        ST_CSCAN: begin
          // ascending scan, so the last hit is the highest index
          if (!self_hit) begin
            for (int f = 0; f < NFACES; f++) begin
              if (hit[f]) begin
                nbr[f]        <= NBR_W'(cidx);
                cell_found[f] <= 1'b1;
              end
            end
          end
          if (cell_last) begin
            sidx  <= '0;
            state <= (seg_count != '0) ? ST_SSCAN : ST_FINISH;
          end else begin
            cidx <= cidx + 1'b1;
          end
        end
        ST_SSCAN: begin
          // first matching segment only, and only where no cell matched
          for (int f = 0; f < NFACES; f++) begin
            if (hit[f] && !cell_found[f] && !seg_found[f]) begin
              nbr[f]       <= seg_code;
              seg_found[f] <= 1'b1;
            end
          end
          if (seg_last) begin
            state <= ST_FINISH;
          end else begin
            sidx <= sidx + 1'b1;
          end
        end
        ST_FINISH: begin
          if (!out_valid || m_tready) begin
            out_valid <= 1'b1;
            out_data  <= {6'b0, nbr, q_reg};
            out_ok    <= ok_reg;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;
  assign m_tuser  = out_ok;

endmodule

`default_nettype wire

[sv/qmnf_checker.sv]
`default_nettype none

module qmnf_checker
  import qmnf_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [63:0] s_tdata,
  input logic [1:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata,
  input logic        m_tuser
);

  // a query transaction keeps the input side busy in the next cycle
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser == OP_QUERY) |=> !s_tready)
    else $error("input ready right after a query transaction");

  // loads and clear leave the input side ready
  a_load_ready: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser != OP_QUERY) |=> s_tready)
    else $error("input not ready after a load or clear transaction");

  // an out of range query reports no neighbours
  a_bad_index: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata[57:10] == {48{1'b1}}))
    else $error("neighbour given for a cell index out of range");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("result changed while stalled");

endmodule

bind quad_mesh_face_neighbour_finder qmnf_checker u_qmnf_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 100ps

module tb;
  import qmnf_pkg::*;

  localparam int CELL_CAP    = 1024;
  localparam int SEG_CAP     = 256;
  localparam int SWEEP_CELLS = 8;       // cells loaded for the segment capacity sweep
  localparam int STAGE_ITEMS = 40;      // random items per idling stage
  localparam int RX_HOLD     = 2500;    // long receiver hold-off, in cycles
  localparam int QUIET_LIMIT = 20000;   // cycles with no transaction before giving up

  // one input transaction as the sender sees it
  typedef struct {
    op_t          op;
    cell_t        corners;   // segments use a and b only
    logic [9:0]   qcell;
  } mesh_op_t;

  // one result transaction
  typedef struct {
    logic [9:0]       cell_index;
    logic             index_ok;
    logic [3:0][11:0] nbr;
  } nbr_answer_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata  = '0;   // corner_a, corner_b, corner_c, corner_d, query_cell
  logic [1:0]  s_tuser  = '0;   // op
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;         // cell_index, nbr_face0, nbr_face1, nbr_face2, nbr_face3
  logic        m_tuser;         // index_ok

  quad_mesh_face_neighbour_finder i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // stimulus and prediction state
  mesh_op_t    mesh_ops[$];        // transactions waiting for the driver
  nbr_answer_t answers[$];         // predicted results, oldest first
  cell_t       cell_mem[CELL_CAP];
  seg_t        seg_mem[SEG_CAP];
  int unsigned n_cells = 0;
  int unsigned n_segs  = 0;
  int          queued_count = 0;
  int          errors = 0;

  // idling knobs, written only by the sequence below
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  bit          hold_trigger  = 1'b0;

  bit          in_taken   = 1'b0;  // input transaction seen at the last rising edge
  int          hold_left  = 0;
  bit          hold_taken = 1'b0;
  int          quiet_cycles = 0;

  // ---------------------------------------------------------------- prediction

  // face f runs over corners 0-1, 1-3, 3-2, 2-0
  function automatic void face_of(cell_t cl, int f, output node_t p, output node_t q);
    case (f)
      0:       begin p = cl.a; q = cl.b; end
      1:       begin p = cl.b; q = cl.d; end
      2:       begin p = cl.d; q = cl.c; end
      default: begin p = cl.c; q = cl.a; end
    endcase
  endfunction

  // both query ends must be among the candidate ends; degenerate faces match loosely
  function automatic bit ends_hit(node_t p, node_t q, node_t r, node_t s);
    return (p == r || p == s) && (q == r || q == s);
  endfunction

  function automatic nbr_answer_t find_neighbours(logic [9:0] qc);
    nbr_answer_t ans;
    node_t p, q, r, s;
    bit found;
    ans.cell_index = qc;
    ans.index_ok   = (qc < n_cells);
    for (int f = 0; f < 4; f++) ans.nbr[f] = '1;   // -1 when nothing matches
    if (ans.index_ok) begin
      for (int f = 0; f < 4; f++) begin
        face_of(cell_mem[qc], f, p, q);
        found = 1'b0;
        // the last matching cell wins
        for (int i = 0; i < n_cells; i++) begin
          if (i == qc) continue;
          for (int g = 0; g < 4; g++) begin
            face_of(cell_mem[i], g, r, s);
            if (ends_hit(p, q, r, s)) begin
              ans.nbr[f] = 12'(i);
              found = 1'b1;
            end
          end
        end
        // otherwise the first matching boundary segment, offset by the cell count
        if (!found) begin
          for (int i = 0; i < n_segs; i++) begin
            if (ends_hit(p, q, seg_mem[i].s0, seg_mem[i].s1)) begin
              ans.nbr[f] = 12'(n_cells + i);
              break;
            end
          end
        end
      end
    end
    return ans;
  endfunction

  task automatic apply_op(op_t op, cell_t cn, logic [9:0] qc);
    case (op)
      OP_LOAD_CELL: if (n_cells < CELL_CAP) begin
        cell_mem[n_cells] = cn;
        n_cells++;
      end
      OP_LOAD_SEG: if (n_segs < SEG_CAP) begin
        seg_mem[n_segs].s0 = cn.a;
        seg_mem[n_segs].s1 = cn.b;
        n_segs++;
      end
      OP_CLEAR: begin
        n_cells = 0;
        n_segs  = 0;
      end
      default: answers.insert(answers.size(), find_neighbours(qc));
    endcase
  endtask

  // ------------------------------------------------------------------ checking

  task automatic compare_field(string name, int want, int got);
    if (want != got) begin
      errors++;
      if (errors <= 10)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  task automatic check_answer(nbr_answer_t got);
    nbr_answer_t want;
    if (answers.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("%0t: unexpected result for cell %0d", $time, got.cell_index);
    end else begin
      want = answers.pop_front();
      compare_field("cell_index", want.cell_index, got.cell_index);
      compare_field("index_ok", want.index_ok, got.index_ok);
      for (int f = 0; f < 4; f++)
        compare_field($sformatf("nbr_face%0d (cell %0d)", f, want.cell_index),
                      $signed(want.nbr[f]), $signed(got.nbr[f]));
    end
  endtask

  // sample both channels at the rising edge; results are checked before the
  // same-edge input is predicted, though a query can never finish that fast
  always @(posedge clk) begin : watch_bus
    nbr_answer_t got;
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= s_tvalid && s_tready;
      if (m_tvalid && m_tready) begin
        got.cell_index = m_tdata[9:0];
        got.index_ok   = m_tuser;
        for (int f = 0; f < 4; f++) got.nbr[f] = m_tdata[10 + 12*f +: 12];
        check_answer(got);
      end
      if (s_tvalid && s_tready)
        apply_op(op_t'(s_tuser), cell_t'(s_tdata[47:0]), s_tdata[57:48]);
    end
  end

  // no transaction on either side for too long means the block is stuck
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
      $display("** quad_mesh_face_neighbour_finder: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ------------------------------------------------------------------- driving

  // sender: a new transaction goes out only once the previous one was taken
  always @(negedge clk) begin : drive_ops
    mesh_op_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_taken) begin
      if (mesh_ops.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        nxt = mesh_ops.pop_front();
        s_tvalid <= 1'b1;
        s_tuser  <= nxt.op;
        s_tdata  <= {6'b0, nxt.qcell, nxt.corners};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver: random back-pressure plus one long hold-off on request
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_trigger && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left  <= RX_HOLD;
      m_tready   <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // ------------------------------------------------------------------ stimulus

  function automatic node_t rnd_node();
    return node_t'($urandom_range(0, 4095));
  endfunction

  function automatic logic [9:0] rnd_q();
    return 10'($urandom_range(0, 1023));
  endfunction

  function automatic node_t grid_node(node_t base, int r, int c, int w);
    return node_t'(base + r*(w + 1) + c);
  endfunction

  task automatic queue_op(op_t op, node_t a, node_t b, node_t c, node_t d, logic [9:0] qc);
    mesh_op_t m;
    m.op        = op;
    m.corners.a = a;
    m.corners.b = b;
    m.corners.c = c;
    m.corners.d = d;
    m.qcell     = qc;
    mesh_ops.insert(mesh_ops.size(), m);
    queued_count++;
  endtask

  // boundary segment along a grid edge, kept most of the time, either direction
  task automatic maybe_edge(node_t e0, node_t e1);
    if ($urandom_range(0, 9) < 7) begin
      if ($urandom_range(0, 1) != 0)
        queue_op(OP_LOAD_SEG, e0, e1, rnd_node(), rnd_node(), rnd_q());
      else
        queue_op(OP_LOAD_SEG, e1, e0, rnd_node(), rnd_node(), rnd_q());
    end
  endtask

  // a small structured grid of quads at a random node offset: cells in random
  // orientation with occasional holes and duplicates, border segments, queries,
  // and a little noise mixed in
  task automatic add_mesh_set();
    int w, h, ncell, r, c, orient, dup;
    node_t base, n00, n01, n10, n11;
    w     = $urandom_range(1, 6);
    h     = $urandom_range(1, 4);
    base  = rnd_node();
    ncell = 0;
    queue_op(OP_CLEAR, rnd_node(), rnd_node(), rnd_node(), rnd_node(), rnd_q());
    for (int k = 0; k < w*h; k++) begin
      r   = k / w;
      c   = k % w;
      n00 = grid_node(base, r,     c,     w);
      n01 = grid_node(base, r,     c + 1, w);
      n10 = grid_node(base, r + 1, c,     w);
      n11 = grid_node(base, r + 1, c + 1, w);
      if ($urandom_range(0, 9) == 0) continue;   // hole in the mesh
      orient = $urandom_range(0, 3);
      dup    = ($urandom_range(0, 7) == 0) ? 2 : 1;
      for (int j = 0; j < dup; j++) begin
        case (orient)
          0: queue_op(OP_LOAD_CELL, n00, n01, n10, n11, rnd_q());
          1: queue_op(OP_LOAD_CELL, n01, n00, n11, n10, rnd_q());   // mirrored
          2: queue_op(OP_LOAD_CELL, n10, n11, n00, n01, rnd_q());   // flipped
          default: queue_op(OP_LOAD_CELL, n01, n11, n00, n10, rnd_q());   // rotated
        endcase
        ncell++;
      end
      if ($urandom_range(0, 19) == 0)
        queue_op(OP_QUERY, rnd_node(), rnd_node(), rnd_node(), rnd_node(),
                 10'($urandom_range(0, ncell)));
    end
    for (int i = 0; i < w; i++) begin
      maybe_edge(grid_node(base, 0, i, w), grid_node(base, 0, i + 1, w));
      maybe_edge(grid_node(base, h, i, w), grid_node(base, h, i + 1, w));
    end
    for (int i = 0; i < h; i++) begin
      maybe_edge(grid_node(base, i, 0, w), grid_node(base, i + 1, 0, w));
      maybe_edge(grid_node(base, i, w, w), grid_node(base, i + 1, w, w));
    end
    if ($urandom_range(0, 2) == 0)
      queue_op(OP_LOAD_SEG, rnd_node(), rnd_node(), rnd_node(), rnd_node(), rnd_q());
    for (int i = $urandom_range(3, 8); i > 0; i--) begin
      if ($urandom_range(0, 9) < 2)   // noise: anything at all
        queue_op(op_t'($urandom_range(0, 3)), rnd_node(), rnd_node(), rnd_node(),
                 rnd_node(), rnd_q());
      if ($urandom_range(0, 9) == 0)
        queue_op(OP_QUERY, rnd_node(), rnd_node(), rnd_node(), rnd_node(), rnd_q());
      else
        queue_op(OP_QUERY, rnd_node(), rnd_node(), rnd_node(), rnd_node(),
                 10'($urandom_range(0, ncell)));
    end
  endtask

  // fill the segment store past capacity behind a few isolated cells; the
  // first segment matches face 3-2 of cell 3, the last one face 1-3 of cell 7,
  // and the dropped extra one would give cell 0 a neighbour if it were stored
  task automatic capacity_sweep();
    node_t e0, e1;
    queue_op(OP_CLEAR, rnd_node(), rnd_node(), rnd_node(), rnd_node(), rnd_q());
    for (int i = 0; i < SWEEP_CELLS; i++)
      queue_op(OP_LOAD_CELL, node_t'(4*i), node_t'(4*i + 1), node_t'(4*i + 2),
               node_t'(4*i + 3), rnd_q());
    for (int j = 0; j < SEG_CAP; j++) begin
      if (j == 0) begin
        e0 = 12'd14;
        e1 = 12'd15;
      end else if (j == SEG_CAP - 1) begin
        e0 = 12'd31;
        e1 = 12'd29;
      end else begin
        // away from every cell node
        e0 = node_t'(1000 + j);
        e1 = node_t'(2000 + j);
      end
      queue_op(OP_LOAD_SEG, e0, e1, rnd_node(), rnd_node(), rnd_q());
    end
    queue_op(OP_LOAD_SEG, 12'd1, 12'd0, rnd_node(), rnd_node(), rnd_q());
    queue_op(OP_QUERY, '0, '0, '0, '0, 10'd0);
    queue_op(OP_QUERY, '0, '0, '0, '0, 10'd3);
    queue_op(OP_QUERY, '0, '0, '0, '0, 10'd7);   // highest segment code
    queue_op(OP_QUERY, '0, '0, '0, '0, 10'd2);
    queue_op(OP_QUERY, '0, '0, '0, '0, 10'(SWEEP_CELLS));
  endtask

  // sender pause: nothing new until every predicted result has come back
  task automatic wait_drained();
    do @(posedge clk);
    while (mesh_ops.size() != 0 || s_tvalid || answers.size() != 0);
  endtask

  initial begin : run_sequence
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    send_idle_pct = 36;
    recv_idle_pct = 67;

    // directed: empty store, extreme node ids, shared and duplicate faces,
    // degenerate faces, segment fallback, out-of-range queries, clear
    queue_op(OP_QUERY,     12'h000, 12'h000, 12'h000, 12'h000, 10'd0);
    queue_op(OP_LOAD_CELL, 12'h000, 12'hfff, 12'haaa, 12'h555, 10'h3ff);
    queue_op(OP_QUERY,     12'hfff, 12'hfff, 12'hfff, 12'hfff, 10'd0);
    queue_op(OP_LOAD_CELL, 12'hfff, 12'h000, 12'h800, 12'h7ff, 10'h000);
    queue_op(OP_LOAD_CELL, 12'h123, 12'h123, 12'h123, 12'h123, 10'h155);
    queue_op(OP_LOAD_CELL, 12'hfff, 12'h000, 12'h800, 12'h7ff, 10'h2aa);
    queue_op(OP_LOAD_SEG,  12'h007, 12'h123, 12'hfff, 12'hfff, 10'h3ff);
    queue_op(OP_LOAD_SEG,  12'h123, 12'h123, 12'h000, 12'h000, 10'h000);
    queue_op(OP_LOAD_SEG,  12'haaa, 12'h555, 12'h000, 12'h000, 10'h000);
    queue_op(OP_LOAD_SEG,  12'h555, 12'haaa, 12'h000, 12'h000, 10'h000);
    queue_op(OP_LOAD_SEG,  12'h000, 12'haaa, 12'h000, 12'h000, 10'h000);
    queue_op(OP_QUERY,     12'h000, 12'h000, 12'h000, 12'h000, 10'd0);
    queue_op(OP_QUERY,     12'h000, 12'h000, 12'h000, 12'h000, 10'd1);
    queue_op(OP_QUERY,     12'h000, 12'h000, 12'h000, 12'h000, 10'd2);
    queue_op(OP_QUERY,     12'h000, 12'h000, 12'h000, 12'h000, 10'd3);
    queue_op(OP_QUERY,     12'h000, 12'h000, 12'h000, 12'h000, 10'd4);
    queue_op(OP_QUERY,     12'hfff, 12'hfff, 12'hfff, 12'hfff, 10'd1023);
    queue_op(OP_CLEAR,     12'hfff, 12'hfff, 12'hfff, 12'hfff, 10'h3ff);
    queue_op(OP_QUERY,     12'h000, 12'h000, 12'h000, 12'h000, 10'd0);
    queue_op(OP_LOAD_CELL, 12'hfff, 12'hfff, 12'hfff, 12'hfff, 10'h000);
    queue_op(OP_LOAD_SEG,  12'hfff, 12'h000, 12'h000, 12'h000, 10'h000);
    queue_op(OP_QUERY,     12'h000, 12'h000, 12'h000, 12'h000, 10'd0);

    // random stages: receiver-heavy idling, sender-heavy idling, then none;
    // the last one opens with a long receiver hold-off to back up the block
    for (int stage = 0; stage < 3; stage++) begin
      int target;
      case (stage)
        0: begin send_idle_pct = 36; recv_idle_pct = 67; end
        1: begin send_idle_pct = 67; recv_idle_pct = 36; end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          hold_trigger  = 1'b1;
        end
      endcase
      target = queued_count + STAGE_ITEMS;
      while (queued_count < target)
        add_mesh_set();
      wait_drained();
    end

    capacity_sweep();
    wait_drained();
    repeat (40) @(posedge clk);

    if (answers.size() != 0) begin
      errors += answers.size();
      $display("%0d results never arrived", answers.size());
    end
    if (errors == 0) begin
      $display("** quad_mesh_face_neighbour_finder: PASSED **");
    end else begin
      $display("** quad_mesh_face_neighbour_finder: FAILED **");
    end
    $finish;
  end

endmodule
